// ===== sv/ebl_pkg.sv =====
// ----------------------------------------------------------------------------
// ebl_pkg
// Shared types and constants for the EMA bandwidth limiter.
// ----------------------------------------------------------------------------
package ebl_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000000;

  localparam int RATE_W = 31;
  localparam int SIZE_W = 16;
  localparam int SENT_W = 32;
  localparam int ELAP_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int NINE_W = RATE_W + 4;
  localparam int DEN_W = ELAP_W + 4;
  localparam int NUM_W = SENT_W + TPS_W + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int REM10_W = 4;

  localparam logic [REM10_W:0] DIV_TEN = 5'd10;
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [RATE_W-1:0] MAX_RATE_RESET = RATE_W'(65536);

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENT_DISCARD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELIABLE_BYPASS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV10,
    ST_MUL,
    ST_QDIV,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/ema_bandwidth_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// ema_bandwidth_limiter_unit
// Send-side policer on a smoothed rate meter with a bit-serial rate update.
// ----------------------------------------------------------------------------
// Send requests and short ticks: the result is registered in the cycle after the request is taken.
// Full rate update: the accepted tick, then divide by ten, shift-add multiply and
//   restoring divide, stepped by the serial shift registers, then a finish step;
//   no new request is taken until its result is registered.
// A request is taken while idle and the output register is empty or being drained.
// Reset (synchronous, rst_n low) clears state and loads the register defaults.
module ema_bandwidth_limiter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [15:0]                       in_pkt_size,
  input  logic                              in_is_reliable,
  input  logic                              in_downstream_ok,
  input  logic [31:0]                       in_elapsed_ticks,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_forwarded,
  output logic                              out_success,
  output logic [30:0]                       out_current_rate,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ebl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ebl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ebl_pkg::state_t state_r, state_nxt;

  logic [ebl_pkg::RATE_W-1:0]  max_rate_r, max_rate_nxt;
  logic                        silent_r, silent_nxt;
  logic                        bypass_r, bypass_nxt;
  logic [ebl_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic [ebl_pkg::SENT_W-1:0]  bytes_r, bytes_nxt;
  logic                        primed_r, primed_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_fwd_r, out_fwd_nxt;
  logic                        out_succ_r, out_succ_nxt;
  logic [ebl_pkg::RATE_W-1:0]  out_rate_r, out_rate_nxt;

  logic [ebl_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ebl_pkg::NINE_W-1:0]  base_r, base_nxt;
  logic [ebl_pkg::REM10_W-1:0] rem10_r, rem10_nxt;
  logic [ebl_pkg::SENT_W-1:0]  sent_r, sent_nxt;
  logic [ebl_pkg::ELAP_W-1:0]  elap_r, elap_nxt;
  logic [ebl_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [ebl_pkg::NUM_W-1:0]   acc_r, acc_nxt;
  logic [ebl_pkg::NUM_W-1:0]   mcand_r, mcand_nxt;
  logic [ebl_pkg::DEN_W-1:0]   rem_r, rem_nxt;

  logic in_fire;
  logic last;

  logic                         exempt;
  logic                         blocked;
  logic [ebl_pkg::SENT_W:0]     bytes_sum;
  logic [ebl_pkg::REM10_W:0]    rs10;
  logic [ebl_pkg::REM10_W:0]    diff10;
  logic                         ge10;
  logic [ebl_pkg::REM10_W-1:0]  rem10_step;
  logic [ebl_pkg::DEN_W-1:0]    elap_rem;
  logic [ebl_pkg::DEN_W:0]      rs;
  logic [ebl_pkg::DEN_W:0]      diff;
  logic                         ge;
  logic                         q_hi;
  logic [ebl_pkg::RATE_W:0]     total;

  // FSM outputs
  always_comb begin
    in_ready  = (state_r == ebl_pkg::ST_IDLE) && (!out_valid_r || out_ready);
    cfg_ready = 1'b1;
  end

  assign in_fire = in_valid && in_ready;
  assign last    = (cnt_r == '0);

  assign out_valid        = out_valid_r;
  assign out_forwarded    = out_fwd_r;
  assign out_success      = out_succ_r;
  assign out_current_rate = out_rate_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ebl_pkg::ST_IDLE: begin
        if (in_fire && in_opcode == ebl_pkg::OP_TICK && in_downstream_ok && primed_r &&
            in_elapsed_ticks != '0) begin
          state_nxt = ebl_pkg::ST_DIV10;
        end
      end
      ebl_pkg::ST_DIV10: begin
        if (last) state_nxt = ebl_pkg::ST_MUL;
      end
      ebl_pkg::ST_MUL: begin
        if (last) state_nxt = ebl_pkg::ST_QDIV;
      end
      ebl_pkg::ST_QDIV: begin
        if (last) state_nxt = ebl_pkg::ST_FINISH;
      end
      ebl_pkg::ST_FINISH: begin
        state_nxt = ebl_pkg::ST_IDLE;
      end
      default: state_nxt = ebl_pkg::ST_IDLE;
    endcase
  end

  // serial step logic
  always_comb begin
    exempt    = bypass_r && in_is_reliable;
    blocked   = !exempt && (rate_r > max_rate_r);
    bytes_sum = {1'b0, bytes_r} + (ebl_pkg::SENT_W + 1)'(in_pkt_size);

    rs10       = {rem10_r, base_r[ebl_pkg::NINE_W-1]};
    ge10       = (rs10 >= ebl_pkg::DIV_TEN);
    diff10     = rs10 - ebl_pkg::DIV_TEN;
    rem10_step = ge10 ? diff10[ebl_pkg::REM10_W-1:0] : rs10[ebl_pkg::REM10_W-1:0];
    elap_rem   = ebl_pkg::DEN_W'(elap_r) * ebl_pkg::DEN_W'(rem10_step);

    rs   = {rem_r, acc_r[ebl_pkg::NUM_W-1]};
    diff = rs - {1'b0, den_r};
    ge   = (rs >= {1'b0, den_r});

    q_hi  = |acc_r[ebl_pkg::NUM_W-1:ebl_pkg::RATE_W];
    total = {1'b0, base_r[ebl_pkg::RATE_W-1:0]} + {1'b0, acc_r[ebl_pkg::RATE_W-1:0]};
  end

  // datapath
  always_comb begin
    max_rate_nxt  = max_rate_r;
    silent_nxt    = silent_r;
    bypass_nxt    = bypass_r;
    rate_nxt      = rate_r;
    bytes_nxt     = bytes_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_fwd_nxt   = out_fwd_r;
    out_succ_nxt  = out_succ_r;
    out_rate_nxt  = out_rate_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    rem10_nxt     = rem10_r;
    sent_nxt      = sent_r;
    elap_nxt      = elap_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    rem_nxt       = rem_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ebl_pkg::REG_MAX_RATE:        max_rate_nxt = cfg_data;
        ebl_pkg::REG_SILENT_DISCARD:  silent_nxt = cfg_data[0];
        ebl_pkg::REG_RELIABLE_BYPASS: bypass_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ebl_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode == ebl_pkg::OP_SEND) begin
            out_valid_nxt = 1'b1;
            out_fwd_nxt   = !blocked;
            out_succ_nxt  = blocked ? silent_r : in_downstream_ok;
            out_rate_nxt  = rate_r;
            if (!blocked && in_downstream_ok) begin
              bytes_nxt = bytes_sum[ebl_pkg::SENT_W] ? '1 : bytes_sum[ebl_pkg::SENT_W-1:0];
            end
          end else if (!in_downstream_ok) begin
            out_valid_nxt = 1'b1;
            out_fwd_nxt   = 1'b0;
            out_succ_nxt  = 1'b0;
            out_rate_nxt  = rate_r;
          end else if (!primed_r) begin
            primed_nxt    = 1'b1;
            bytes_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_fwd_nxt   = 1'b0;
            out_succ_nxt  = 1'b1;
            out_rate_nxt  = rate_r;
          end else if (in_elapsed_ticks == '0) begin
            rate_nxt      = ebl_pkg::RATE_MAX;
            bytes_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_fwd_nxt   = 1'b0;
            out_succ_nxt  = 1'b1;
            out_rate_nxt  = ebl_pkg::RATE_MAX;
          end else begin
            sent_nxt  = bytes_r;
            bytes_nxt = '0;
            elap_nxt  = in_elapsed_ticks;
            den_nxt   = (ebl_pkg::DEN_W'(in_elapsed_ticks) << 3) +
                        (ebl_pkg::DEN_W'(in_elapsed_ticks) << 1);
            base_nxt  = (ebl_pkg::NINE_W'(rate_r) << 3) + ebl_pkg::NINE_W'(rate_r);
            rem10_nxt = '0;
            cnt_nxt   = ebl_pkg::CNT_W'(ebl_pkg::NINE_W - 1);
          end
        end
      end
      ebl_pkg::ST_DIV10: begin
        base_nxt  = {base_r[ebl_pkg::NINE_W-2:0], ge10};
        rem10_nxt = rem10_step;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          acc_nxt   = ebl_pkg::NUM_W'(elap_rem);
          mcand_nxt = ebl_pkg::NUM_W'(ebl_pkg::TICKS_PER_SECOND);
          cnt_nxt   = ebl_pkg::CNT_W'(ebl_pkg::SENT_W - 1);
        end
      end
      ebl_pkg::ST_MUL: begin
        acc_nxt   = acc_r + (sent_r[0] ? mcand_r : '0);
        mcand_nxt = mcand_r << 1;
        sent_nxt  = sent_r >> 1;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          rem_nxt = '0;
          cnt_nxt = ebl_pkg::CNT_W'(ebl_pkg::NUM_W - 1);
        end
      end
      ebl_pkg::ST_QDIV: begin
        acc_nxt = {acc_r[ebl_pkg::NUM_W-2:0], ge};
        rem_nxt = ge ? diff[ebl_pkg::DEN_W-1:0] : rs[ebl_pkg::DEN_W-1:0];
        cnt_nxt = cnt_r - 1'b1;
      end
      ebl_pkg::ST_FINISH: begin
        rate_nxt      = (q_hi || total[ebl_pkg::RATE_W]) ? ebl_pkg::RATE_MAX
                                                         : total[ebl_pkg::RATE_W-1:0];
        out_valid_nxt = 1'b1;
        out_fwd_nxt   = 1'b0;
        out_succ_nxt  = 1'b1;
        out_rate_nxt  = (q_hi || total[ebl_pkg::RATE_W]) ? ebl_pkg::RATE_MAX
                                                         : total[ebl_pkg::RATE_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ebl_pkg::ST_IDLE;
      max_rate_r  <= ebl_pkg::MAX_RATE_RESET;
      silent_r    <= 1'b0;
      bypass_r    <= 1'b0;
      rate_r      <= '0;
      bytes_r     <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      max_rate_r  <= max_rate_nxt;
      silent_r    <= silent_nxt;
      bypass_r    <= bypass_nxt;
      rate_r      <= rate_nxt;
      bytes_r     <= bytes_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fwd_r  <= out_fwd_nxt;
    out_succ_r <= out_succ_nxt;
    out_rate_r <= out_rate_nxt;
    base_r     <= base_nxt;
    rem10_r    <= rem10_nxt;
    sent_r     <= sent_nxt;
    elap_r     <= elap_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    rem_r      <= rem_nxt;
  end

endmodule
